FILE: rtl/core/simple_moving_average_macros.svh
`ifndef SIMPLE_MOVING_AVERAGE_MACROS_SVH
`define SIMPLE_MOVING_AVERAGE_MACROS_SVH

// Check an implication in the same cycle, sampled on clk, off during reset
`define SMA_ASSERT_NOW(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Check an implication in the next cycle, sampled on clk, off during reset
`define SMA_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

FILE: rtl/core/sma_pkg.sv
package sma_pkg;

	// Fixed field widths of the request and result items
	localparam int SAMPLE_WIDTH   = 16;
	localparam int WLEN_W         = 7;
	localparam int USED_W         = 7;
	localparam int MAX_WINDOW_DEF = 64;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           start_req;
	} sma_in_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] average;
		logic [USED_W-1:0]              samples_used;
	} sma_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ADJ_RD,
		ST_ADJ_ACC,
		ST_WRITE,
		ST_DIV_INIT,
		ST_DIVIDE,
		ST_DONE
	} sma_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic setup;
		logic adj_rd;
		logic adj_acc;
		logic write;
		logic div_init;
		logic div_step;
		logic load_out;
	} sma_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic adj_none;
		logic adj_last;
		logic out_free;
	} sma_sts_t;

endpackage

FILE: rtl/core/sma_ctrl.sv
module sma_ctrl #(
	parameter int DIV_STEPS = 23
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sma_pkg::sma_sts_t sts,
	output sma_pkg::sma_cmd_t cmd
);
	import sma_pkg::*;

	localparam int DC_W = $clog2(DIV_STEPS + 1);

	sma_state_t      state_q;
	sma_state_t      state_d;
	logic [DC_W-1:0] div_cnt_q;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Count divider steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (state_q == ST_DIV_INIT) begin
			div_cnt_q <= DC_W'(DIV_STEPS - 1);
		end else if (state_q == ST_DIVIDE) begin
			div_cnt_q <= div_cnt_q - DC_W'(1);
		end
	end

	// Pick next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = sts.adj_none ? ST_WRITE : ST_ADJ_RD;
			end
			ST_ADJ_RD: begin
				state_d = ST_ADJ_ACC;
			end
			ST_ADJ_ACC: begin
				state_d = sts.adj_last ? ST_WRITE : ST_ADJ_RD;
			end
			ST_WRITE: begin
				state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_cnt_q == '0) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Drive datapath commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_SETUP:    cmd.setup    = 1'b1;
			ST_ADJ_RD:   cmd.adj_rd   = 1'b1;
			ST_ADJ_ACC:  cmd.adj_acc  = 1'b1;
			ST_WRITE:    cmd.write    = 1'b1;
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIVIDE:   cmd.div_step = 1'b1;
			ST_DONE:     cmd.load_out = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/core/sma_datapath.sv
module sma_datapath #(
	parameter int MAX_WINDOW = 64,
	parameter int SUM_W      = 23
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sma_pkg::sma_in_t              in_data,
	input  logic                          cfg_we,
	input  logic [sma_pkg::WLEN_W-1:0]    cfg_wdata,
	input  sma_pkg::sma_cmd_t             cmd,
	output sma_pkg::sma_sts_t             sts,
	output logic                          out_valid,
	input  logic                          out_stall,
	output sma_pkg::sma_out_t             out_data
);
	import sma_pkg::*;

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);

	// Configuration and sequence state
	logic [WLEN_W-1:0]              wlen_q;
	logic [AW-1:0]                  wp_q;
	logic [CNT_W-1:0]               fill_q;
	logic [CNT_W-1:0]               prev_q;
	logic signed [SUM_W-1:0]        sum_q;

	// Per-request working registers
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic [CNT_W-1:0]               used_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           sub_q;
	logic [AW-1:0]                  rd_addr_q;
	logic signed [SAMPLE_WIDTH-1:0] rd_data_q;

	// Divider registers
	logic [CNT_W-1:0]               rem_q;
	logic [SUM_W-1:0]               quo_q;
	logic                           neg_q;

	// Result register
	sma_out_t                       out_q;
	logic                           out_valid_q;

	// Sample ring
	logic signed [SAMPLE_WIDTH-1:0] mem [MAX_WINDOW];

	// Setup terms
	logic [CNT_W-1:0]               eff;
	logic [CNT_W-1:0]               fill_new;
	logic [CNT_W-1:0]               used_new;
	logic                           sub_new;
	logic [CNT_W-1:0]               age;
	logic [CNT_W-1:0]               cnt_new;
	logic [CNT_W:0]                 wp_x;
	logic [CNT_W:0]                 age_x;
	logic [CNT_W:0]                 addr_x;

	// Divider terms
	logic [SUM_W-1:0]               sum_mag;
	logic [CNT_W:0]                 trial;
	logic                           fits;
	logic [SUM_W-1:0]               avg_full;

	// Clamp the window and size this average
	always_comb begin
		if (wlen_q == '0) begin
			eff = CNT_W'(1);
		end else if (int'(wlen_q) > MAX_WINDOW) begin
			eff = CNT_W'(MAX_WINDOW);
		end else begin
			eff = CNT_W'(wlen_q);
		end
		fill_new = (fill_q == CNT_W'(MAX_WINDOW)) ? fill_q : fill_q + CNT_W'(1);
		used_new = (eff < fill_new) ? eff : fill_new;
		// Old sum covers ages 1..prev; new one needs ages 1..used-1 plus the sample
		sub_new  = (prev_q >= used_new);
		age      = sub_new ? used_new : prev_q + CNT_W'(1);
		cnt_new  = sub_new ? prev_q - used_new + CNT_W'(1)
		                   : used_new - CNT_W'(1) - prev_q;
		wp_x     = (CNT_W+1)'(wp_q);
		age_x    = (CNT_W+1)'(age);
		addr_x   = (wp_x >= age_x) ? wp_x - age_x
		                           : wp_x + (CNT_W+1)'(MAX_WINDOW) - age_x;
	end

	// Restoring divider step on the magnitude
	always_comb begin
		sum_mag  = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
		trial    = {rem_q, quo_q[SUM_W-1]};
		fits     = (trial >= {1'b0, used_q});
		avg_full = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
	end

	// Window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_W'(1);
		end else if (cfg_we) begin
			wlen_q <= cfg_wdata;
		end
	end

	// Sequence state: clear on start, update through setup, adjust and write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			prev_q <= '0;
			sum_q  <= '0;
		end else if (cmd.accept) begin
			if (in_data.start_req) begin
				wp_q   <= '0;
				fill_q <= '0;
				prev_q <= '0;
				sum_q  <= '0;
			end
		end else if (cmd.setup) begin
			fill_q <= fill_new;
			prev_q <= used_new;
		end else if (cmd.adj_acc) begin
			sum_q <= sub_q ? sum_q - SUM_W'(rd_data_q) : sum_q + SUM_W'(rd_data_q);
		end else if (cmd.write) begin
			wp_q  <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
			sum_q <= sum_q + SUM_W'(sample_q);
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= in_data.sample;
		end
		if (cmd.setup) begin
			used_q    <= used_new;
			cnt_q     <= cnt_new;
			sub_q     <= sub_new;
			rd_addr_q <= addr_x[AW-1:0];
		end else if (cmd.adj_acc) begin
			cnt_q     <= cnt_q - CNT_W'(1);
			rd_addr_q <= (rd_addr_q == '0) ? AW'(MAX_WINDOW - 1) : rd_addr_q - AW'(1);
		end
		if (cmd.div_init) begin
			neg_q <= sum_q[SUM_W-1];
			quo_q <= sum_mag;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, used_q}) : CNT_W'(trial);
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
		if (cmd.load_out) begin
			out_q.average      <= avg_full[SAMPLE_WIDTH-1:0];
			out_q.samples_used <= USED_W'(used_q);
		end
	end

	// Ring write and registered read
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[wp_q] <= sample_q;
		end
		if (cmd.adj_rd) begin
			rd_data_q <= mem[rd_addr_q];
		end
	end

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.adj_none = (cnt_new == '0);
	assign sts.adj_last = (cnt_q == CNT_W'(1));
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: rtl/core/simple_moving_average.sv
// Boxcar moving average of signed 16-bit samples. Each request returns one
// result: the mean of the last window_length samples of the current sequence
// (fewer during warm-up), truncated toward zero, with the count it covers.
// start_req begins a new sequence. A running sum is corrected per request by
// reading the ring memory once per sample entering or leaving the window
// (one read each at a steady window, none during warm-up, more after the
// window is changed), then a restoring divider produces one quotient bit per
// cycle over the sum width (SAMPLE_WIDTH + log2(MAX_WINDOW) + 1 = 23 bits by
// default). A request passes through setup, a read and an accumulate step for
// each memory read, the ring write, divider setup and the divide steps. The
// block takes a new request while an earlier result still waits on out_stall.
// window_length 0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW;
// write it only while the block is idle. No clearing pass is needed after
// reset: only samples of the current sequence are ever read.
module simple_moving_average #(
	parameter int MAX_WINDOW = sma_pkg::MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  sma_pkg::sma_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output sma_pkg::sma_out_t          out_data,
	input  logic                       cfg_we,
	input  logic [sma_pkg::WLEN_W-1:0] cfg_wdata
);
	import sma_pkg::*;

`include "simple_moving_average_macros.svh"

	localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW) + 1;

	sma_cmd_t cmd;
	sma_sts_t sts;

	sma_ctrl #(
		.DIV_STEPS(SUM_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	sma_datapath #(
		.MAX_WINDOW(MAX_WINDOW),
		.SUM_W     (SUM_W)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// Busy right after a request is taken
	`SMA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request taken while busy")
	// Never overwrite a result that is still waiting
	`SMA_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid || !out_stall, "result overwritten")
	// A delivered result always covers at least one sample
	`SMA_ASSERT_NOW(a_used_nonzero, out_valid, out_data.samples_used != '0, "empty average")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import sma_pkg::*;

	localparam int RING_DEPTH  = MAX_WINDOW_DEF;
	localparam int RING_AW     = $clog2(RING_DEPTH);
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYC  = 200;
	localparam int HOLD_CYC    = 400;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	sma_in_t              in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	sma_out_t             out_data;
	logic                 cfg_we = 1'b0;
	logic [WLEN_W-1:0]    cfg_wdata = '0;

	// Shadow state of the averager
	logic signed [SAMPLE_WIDTH-1:0] ring [0:RING_DEPTH-1];
	int                             fill_cnt = 0;
	int                             wr_ptr = 0;
	logic [WLEN_W-1:0]              win_len = 1;

	sma_out_t avg_expected [$];

	int cycle_count = 0;
	int hold_end = 0;
	int stall_pct = 0;
	int stall_left = 0;
	int fail_count = 0;
	bit idle_on = 1'b0;

	simple_moving_average u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stall the result side: long hold on request, else random bursts
	always @(posedge clk) begin
		if (cycle_count < hold_end) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each result with the oldest pending average
	always @(posedge clk) begin
		sma_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (avg_expected.size() == 0) begin
				$error("unexpected result: average %0d samples_used %0d",
					out_data.average, out_data.samples_used);
				fail_count++;
			end else begin
				want = avg_expected.pop_front();
				if (out_data.average !== want.average) begin
					$error("average: expected %0d, actual %0d",
						want.average, out_data.average);
					fail_count++;
				end
				if (out_data.samples_used !== want.samples_used) begin
					$error("samples_used: expected %0d, actual %0d",
						want.samples_used, out_data.samples_used);
					fail_count++;
				end
			end
		end
	end

	// Advance the shadow ring and return the mean over the live window
	function automatic sma_out_t predict_average(sma_in_t req);
		int span;
		int acc;
		int idx;
		sma_out_t res;
		if (req.start_req) begin
			fill_cnt = 0;
			wr_ptr = 0;
		end
		ring[wr_ptr[RING_AW-1:0]] = req.sample;
		wr_ptr = (wr_ptr + 1) % RING_DEPTH;
		if (fill_cnt < RING_DEPTH)
			fill_cnt++;
		if (win_len == 0)
			span = 1;
		else if (win_len > RING_DEPTH)
			span = RING_DEPTH;
		else
			span = int'(win_len);
		if (span > fill_cnt)
			span = fill_cnt;
		acc = 0;
		for (int k = 0; k < span; k++) begin
			idx = (wr_ptr + 2 * RING_DEPTH - 1 - k) % RING_DEPTH;
			acc += int'(ring[idx[RING_AW-1:0]]);
		end
		res.average = SAMPLE_WIDTH'(acc / span);
		res.samples_used = USED_W'(span);
		return res;
	endfunction

	// Drop valid for a random gap, mostly short
	task automatic sender_gap();
		int n;
		if (!idle_on)
			return;
		case ($urandom_range(0, 19))
			0: n = $urandom_range(10, 40);
			1, 2, 3, 4, 5, 6, 7: n = $urandom_range(1, 3);
			default: n = 0;
		endcase
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Offer one request and hold it until taken
	task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] value, bit start);
		sma_in_t req;
		req.sample = value;
		req.start_req = start;
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
		avg_expected.push_back(predict_average(req));
		sender_gap();
	endtask

	// Idle the input and wait for every pending result
	task automatic drain();
		in_valid <= 1'b0;
		while (avg_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_window(logic [WLEN_W-1:0] w);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_len = w;
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
			default: return 16'($urandom);
		endcase
	endfunction

	// Reset window of one; the first sample opens a sequence on its own
	task automatic test_reset_window();
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(-16'sd1, 1'b0);
	endtask

	// Extreme samples, truncation toward zero, zero and oversized windows
	task automatic test_window_extremes();
		set_window(2);
		send_sample(-16'sd1, 1'b1);
		send_sample(-16'sd2, 1'b0);
		send_sample(16'sd3, 1'b0);
		set_window(64);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh8001, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		set_window(0);
		send_sample(16'sd5, 1'b1);
		send_sample(-16'sd7, 1'b0);
		set_window(127);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		set_window(65);
		send_sample(-16'sd3, 1'b0);
	endtask

	// Shrink and grow the window over a sequence already held
	task automatic test_window_change();
		set_window(3);
		send_sample(16'sd100, 1'b1);
		for (int i = 0; i < 4; i++)
			send_sample(SAMPLE_WIDTH'(-41 * i), 1'b0);
		set_window(1);
		send_sample(16'sd9, 1'b0);
		set_window(64);
		send_sample(16'sd10, 1'b0);
	endtask

	// Hold results off so the block backs up, then pause until clear
	task automatic test_backpressure();
		idle_on = 1'b0;
		set_window(8);
		hold_end <= cycle_count + HOLD_CYC;
		for (int i = 0; i < 30; i++)
			send_sample(random_sample(), i == 0);
		drain();
	endtask

	// Random sequences across many window settings
	task automatic test_random_stream();
		logic [WLEN_W-1:0] w;
		for (int ph = 0; ph < 17; ph++) begin
			case (ph)
				0: w = 1;
				1: w = 64;
				2: w = 0;
				3: w = 127;
				default: begin
					case ($urandom_range(0, 9))
						0: w = 0;
						1: w = WLEN_W'($urandom_range(65, 127));
						default: w = WLEN_W'($urandom_range(1, 64));
					endcase
				end
			endcase
			set_window(w);
			idle_on = ($urandom_range(0, 3) != 0);
			stall_pct <= idle_on ? $urandom_range(10, 40) : 0;
			for (int i = 0; i < 100; i++)
				send_sample(random_sample(),
					(i == 0 && $urandom_range(0, 2) == 0) || $urandom_range(0, 47) == 0);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		stall_pct <= 25;
		test_reset_window();
		test_window_extremes();
		test_window_change();
		test_backpressure();
		test_random_stream();

		drain();
		repeat (SETTLE_CYC) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
